// ===== src/integer_text_formatter_top_macros.svh =====
// Assertion macros shared by the integer text formatter RTL.
`ifndef INTEGER_TEXT_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ITF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("integer text formatter: check failed");
// Antecedent implies consequent in the following cycle.
`define ITF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("integer text formatter: check failed");
`else
`define ITF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ITF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/itf_pkg.sv =====
// Types, codes and helper functions of the integer text formatter.
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;
	localparam int MAX_WIDTH_DEF = 32;
	localparam int NDIG          = 10;
	localparam int DIG_IDX_W     = $clog2(NDIG);

	localparam logic [2:0] CMD_UDEC = 3'd0;
	localparam logic [2:0] CMD_SDEC = 3'd1;
	localparam logic [2:0] CMD_LHEX = 3'd2;
	localparam logic [2:0] CMD_UHEX = 3'd3;
	localparam logic [2:0] CMD_PTR  = 3'd4;

	localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
	localparam int          RECIP_SH = 35;
	localparam logic [5:0]  PTR_DIGS = 6'd8;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_X     = 7'h78;
	localparam logic [6:0] CH_UA    = 7'h41;
	localparam logic [6:0] CH_LA    = 7'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PFX0,
		ST_PFX1,
		ST_SIGN,
		ST_PAD,
		ST_DIGIT
	} state_t;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_X,
		SEL_MINUS,
		SEL_PAD,
		SEL_DIGIT
	} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      pad_step;
		logic      dig_step;
		char_sel_t sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic neg;
		logic ptr;
		logic conv_last;
		logic conv_pad;
		logic pad_any;
		logic pad_one;
		logic dig_last;
	} dp_stat_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] base;
		base = upper ? CH_UA : CH_LA;
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {3'b000, d};
		end else begin
			digit_char = base + {3'b000, d} - 7'd10;
		end
	endfunction
endpackage
`default_nettype wire

// ===== src/integer_text_formatter_top.sv =====
// Top level of the integer text formatter.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_text_formatter_top_macros.svh"
// Formats one 32-bit value per input transaction as ASCII text, one character per
// output transaction, most significant first, with tlast on the final character.
// Modes by tuser: 0 unsigned decimal, 1 signed decimal, 2 lower hex, 3 upper hex,
// 4 pointer ("0x" and eight upper-case digits); codes 5 to 7 are taken and give no
// output. One item is handled at a time: after acceptance the shared divide-by-ten
// unit (or nibble shift for hex) yields one digit per cycle, then one character
// leaves per cycle while the sink is ready.
module integer_text_formatter_top #(
	parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // value[31:0], width[37:32], pad_zero[38], zero[39]
	input  wire logic [2:0]  s_tuser,  // cmd[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // text_char[6:0], zero[7]
	output logic             m_tlast
);
	import itf_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      bad_take;

	itf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tlast  (m_tlast)
	);

	itf_dpath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dpath (
		.clk     (clk),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata)
	);

	assign bad_take = s_tvalid && s_tready && (s_tuser > CMD_PTR);

	// The block never offers a character while it can take a new item.
	`ITF_ASSERT_NOW(a_no_overlap, clk, arst_n, m_tvalid, !s_tready)
	// After the final character of a number the block is free again.
	`ITF_ASSERT_NEXT(a_last_frees, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready)
	// An unused mode is dropped without producing any character.
	`ITF_ASSERT_NEXT(a_bad_cmd_drop, clk, arst_n, bad_take, s_tready && !m_tvalid)
endmodule
`default_nettype wire

// ===== src/itf_dpath.sv =====
// Datapath: operand capture, digit extraction, digit store and character selection.
`timescale 1ns / 1ps
`default_nettype none
module itf_dpath #(
	parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic [39:0]       s_tdata,
	input  wire logic [2:0]        s_tuser,
	input  wire itf_pkg::ctrl_cmd_t cmd,
	output itf_pkg::dp_stat_t      stat,
	output logic [7:0]             m_tdata
);
	import itf_pkg::*;

	logic [31:0]          mag_q;
	logic                 neg_q;
	logic                 base16_q;
	logic                 upper_q;
	logic                 ptr_q;
	logic [6:0]           pad_char_q;
	logic [5:0]           wid_q;
	logic [DIG_IDX_W-1:0] ndig_q;
	logic [DIG_IDX_W-1:0] dig_idx_q;
	logic [5:0]           pad_cnt_q;
	logic [3:0]           dig_q [NDIG];

	logic [31:0] in_value;
	logic [5:0]  in_width;
	logic        in_pad_zero;
	logic        in_neg;
	logic        in_ptr;
	logic [5:0]  wid_sat;
	logic [5:0]  wid_load;
	logic [63:0] prod;
	logic [31:0] quot;
	logic [3:0]  q10_lo;
	logic [3:0]  rem;
	logic [3:0]  digit;
	logic [31:0] mag_next;
	logic [5:0]  ndig_inc;
	logic [6:0]  ch;

	assign in_value    = s_tdata[31:0];
	assign in_width    = s_tdata[37:32];
	assign in_pad_zero = s_tdata[38];
	assign in_neg      = (s_tuser == CMD_SDEC) && in_value[31];
	assign in_ptr      = (s_tuser == CMD_PTR);

	always_comb begin
		wid_sat = (32'(in_width) > MAX_WIDTH) ? 6'(MAX_WIDTH) : in_width;
		if (in_ptr) begin
			wid_load = PTR_DIGS;
		end else if (in_neg && (wid_sat != 6'd0)) begin
			wid_load = wid_sat - 6'd1;
		end else begin
			wid_load = wid_sat;
		end
	end

	// Division by ten through the reciprocal; only the low nibble of quot*10 is
	// needed for the remainder, since the remainder is below ten.
	assign prod     = 64'(mag_q) * 64'(RECIP10);
	assign quot     = 32'(prod[63:RECIP_SH]);
	assign q10_lo   = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign rem      = mag_q[3:0] - q10_lo;
	assign digit    = base16_q ? mag_q[3:0] : rem;
	assign mag_next = base16_q ? {4'h0, mag_q[31:4]} : quot;
	assign ndig_inc = 6'(ndig_q) + 6'd1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q      <= in_neg ? (~in_value + 32'd1) : in_value;
			neg_q      <= in_neg;
			ptr_q      <= in_ptr;
			base16_q   <= (s_tuser == CMD_LHEX) || (s_tuser == CMD_UHEX) || in_ptr;
			upper_q    <= (s_tuser == CMD_UHEX) || in_ptr;
			pad_char_q <= (in_ptr || in_pad_zero) ? CH_ZERO : CH_SPACE;
			wid_q      <= wid_load;
			ndig_q     <= '0;
		end
		if (cmd.conv_step) begin
			dig_q[ndig_q] <= digit;
			ndig_q        <= ndig_q + 1'b1;
			mag_q         <= mag_next;
			pad_cnt_q     <= stat.conv_pad ? (wid_q - ndig_inc) : 6'd0;
			dig_idx_q     <= ndig_q;
		end
		if (cmd.pad_step) begin
			pad_cnt_q <= pad_cnt_q - 6'd1;
		end
		if (cmd.dig_step) begin
			dig_idx_q <= dig_idx_q - 1'b1;
		end
	end

	always_comb begin
		stat.neg       = neg_q;
		stat.ptr       = ptr_q;
		stat.conv_last = (mag_next == 32'd0);
		stat.conv_pad  = (wid_q > ndig_inc);
		stat.pad_any   = (pad_cnt_q != 6'd0);
		stat.pad_one   = (pad_cnt_q == 6'd1);
		stat.dig_last  = (dig_idx_q == '0);
	end

	always_comb begin
		case (cmd.sel)
			SEL_ZERO:  ch = CH_ZERO;
			SEL_X:     ch = CH_X;
			SEL_MINUS: ch = CH_MINUS;
			SEL_PAD:   ch = pad_char_q;
			SEL_DIGIT: ch = digit_char(dig_q[dig_idx_q], upper_q);
			default:   ch = CH_ZERO;
		endcase
	end

	assign m_tdata = {1'b0, ch};
endmodule
`default_nettype wire

// ===== src/itf_ctrl.sv =====
// Controller state machine: sequences conversion and character output.
`timescale 1ns / 1ps
`default_nettype none
module itf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic [2:0]        s_tuser,
	input  wire logic              m_tready,
	input  wire itf_pkg::dp_stat_t stat,
	output itf_pkg::ctrl_cmd_t     cmd,
	output logic                   s_tready,
	output logic                   m_tvalid,
	output logic                   m_tlast
);
	import itf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   take;
	logic   cmd_ok;
	logic   out_hs;

	assign cmd_ok = (s_tuser <= CMD_PTR);
	assign take   = (state_q == ST_IDLE) && s_tvalid;
	assign out_hs = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				// Unused codes are taken and produce no characters.
				if (take && cmd_ok) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (stat.conv_last) begin
					if (stat.ptr)           state_d = ST_PFX0;
					else if (stat.neg)      state_d = ST_SIGN;
					else if (stat.conv_pad) state_d = ST_PAD;
					else                    state_d = ST_DIGIT;
				end
			end
			ST_PFX0: begin
				if (out_hs) state_d = ST_PFX1;
			end
			ST_PFX1, ST_SIGN: begin
				if (out_hs) state_d = stat.pad_any ? ST_PAD : ST_DIGIT;
			end
			ST_PAD: begin
				if (out_hs && stat.pad_one) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (out_hs && stat.dig_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load      = take;
		cmd.conv_step = (state_q == ST_CONV);
		cmd.pad_step  = 1'b0;
		cmd.dig_step  = 1'b0;
		cmd.sel       = SEL_DIGIT;
		s_tready      = (state_q == ST_IDLE);
		m_tvalid      = 1'b0;
		m_tlast       = 1'b0;
		case (state_q)
			ST_PFX0: begin
				m_tvalid = 1'b1;
				cmd.sel  = SEL_ZERO;
			end
			ST_PFX1: begin
				m_tvalid = 1'b1;
				cmd.sel  = SEL_X;
			end
			ST_SIGN: begin
				m_tvalid = 1'b1;
				cmd.sel  = SEL_MINUS;
			end
			ST_PAD: begin
				m_tvalid     = 1'b1;
				cmd.sel      = SEL_PAD;
				cmd.pad_step = m_tready;
			end
			ST_DIGIT: begin
				m_tvalid     = 1'b1;
				cmd.sel      = SEL_DIGIT;
				cmd.dig_step = m_tready;
				m_tlast      = stat.dig_last;
			end
			default: begin
				m_tvalid = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== verif/integer_text_formatter_checker.sv =====
// Checker that predicts and compares the character stream of the integer text formatter.
`timescale 1ns / 1ps
module integer_text_formatter_checker #(
	parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], width[37:32], pad_zero[38], zero[39]
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // text_char[6:0], zero[7]
	input  logic        m_tlast,
	output int          err_count,
	output int          pending_count
);
	import itf_pkg::*;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} text_beat_t;

	text_beat_t text_due[$];
	int mismatches = 0;

	initial begin
		err_count = 0;
		pending_count = 0;
	end

	// Builds the text of one number and queues it character by character.
	task automatic predict_text(input logic [2:0] cmd, input logic [31:0] operand,
			input logic [5:0] field_w, input logic pad_zero);
		logic [6:0] text[$];
		logic [6:0] digits[$];
		logic [31:0] mag;
		logic [6:0] pad_ch;
		logic [3:0] d;
		logic hex;
		logic upper;
		int min_w;
		text_beat_t beat;
		mag = operand;
		min_w = (field_w > MAX_WIDTH) ? MAX_WIDTH : int'(field_w);
		pad_ch = pad_zero ? CH_ZERO : CH_SPACE;
		hex = 1'b0;
		upper = 1'b0;
		case (cmd)
			CMD_UDEC: ;
			CMD_SDEC: begin
				// The minus sign uses up one place of the field width.
				if (operand[31]) begin
					text.push_back(CH_MINUS);
					mag = ~operand + 32'd1;
					if (min_w > 0)
						min_w--;
				end
			end
			CMD_LHEX: hex = 1'b1;
			CMD_UHEX: begin
				hex = 1'b1;
				upper = 1'b1;
			end
			CMD_PTR: begin
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				hex = 1'b1;
				upper = 1'b1;
				min_w = 8;
				pad_ch = CH_ZERO;
			end
			default: return;
		endcase
		do begin
			if (hex) begin
				d = mag[3:0];
				mag = mag >> 4;
			end else begin
				d = 4'(mag % 32'd10);
				mag = mag / 32'd10;
			end
			if (d < 4'd10)
				digits.push_front(CH_ZERO + {3'b000, d});
			else
				digits.push_front((upper ? CH_UA : CH_LA) + {3'b000, d} - 7'd10);
		end while (mag != 32'd0);
		for (int k = digits.size(); k < min_w; k++)
			text.push_back(pad_ch);
		foreach (digits[i])
			text.push_back(digits[i]);
		foreach (text[i]) begin
			beat.ch = text[i];
			beat.last = (i == text.size() - 1);
			text_due.push_back(beat);
		end
	endtask

	task automatic flag_mismatch(input string what, input text_beat_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
				$realtime, what, want.ch, want.last, m_tdata[6:0], m_tlast);
	endtask

	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n) begin
			// Input first: an output in the same cycle always belongs to an older number.
			if (s_tvalid && s_tready)
				predict_text(s_tuser, s_tdata[31:0], s_tdata[37:32], s_tdata[38]);
			if (m_tvalid && m_tready) begin
				if (text_due.size() == 0) begin
					want = '0;
					flag_mismatch("unexpected character", want);
				end else begin
					want = text_due.pop_front();
					if (want.ch != m_tdata[6:0] || want.last != m_tlast)
						flag_mismatch("character mismatch", want);
				end
			end
			err_count <= mismatches;
			pending_count <= text_due.size();
		end
	end
endmodule

// ===== verif/tb.sv =====
// Stimulus and verdict for the integer text formatter testbench.
`timescale 1ns / 1ps
module tb;
	import itf_pkg::*;

	localparam int HOLD_START = 600;
	localparam int HOLD_LEN   = 300;
	localparam int RX_CALM_LO = 2000;
	localparam int RX_CALM_HI = 3000;
	localparam int RAND_ITEMS = 90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	int          err_count;
	int          pending_count;
	logic        tx_calm = 1'b0;

	integer_text_formatter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	integer_text_formatter_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.err_count    (err_count),
		.pending_count(pending_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offers one number and returns at the edge where the transaction is taken.
	task automatic send_number(input logic [2:0] cmd, input logic [31:0] operand,
			input logic [5:0] field_w, input logic pad_zero);
		int gap;
		gap = 0;
		while (!tx_calm && $urandom_range(99) < 38)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= {1'b0, 7'($urandom), 32'($urandom)};
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, pad_zero, field_w, operand};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(6))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'($urandom_range(999));
			4: return 32'h8000_0000 | 32'($urandom);
			default: return 32'($urandom);
		endcase
	endfunction

	// Receiver: random back-pressure, one long hold-off to fill the block, one calm stretch.
	initial begin
		int cycle;
		cycle = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_LEN)
				m_tready <= 1'b0;
			else if (cycle >= RX_CALM_LO && cycle < RX_CALM_HI)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 38);
			cycle++;
			@(posedge clk);
		end
	end

	initial begin
		int sent;
		int idx;
		logic [2:0] cmd;
		logic [5:0] field_w;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_number(CMD_UDEC, 32'd0, 6'd0, 1'b0);
		send_number(CMD_UDEC, 32'hFFFF_FFFF, 6'd0, 1'b0);
		send_number(CMD_UDEC, 32'd42, 6'd5, 1'b0);
		send_number(CMD_UDEC, 32'd42, 6'd5, 1'b1);
		send_number(CMD_UDEC, 32'd123, 6'd2, 1'b1);
		send_number(CMD_UDEC, 32'd7, 6'd63, 1'b1);
		send_number(CMD_UDEC, 32'd1, 6'd32, 1'b0);
		send_number(CMD_SDEC, 32'h8000_0000, 6'd0, 1'b0);
		send_number(CMD_SDEC, 32'hFFFF_FFFF, 6'd0, 1'b1);
		send_number(CMD_SDEC, 32'hFFFF_FFFB, 6'd4, 1'b1);
		send_number(CMD_SDEC, 32'hFFFF_FFFB, 6'd4, 1'b0);
		send_number(CMD_SDEC, 32'h7FFF_FFFF, 6'd12, 1'b0);
		send_number(CMD_SDEC, 32'hFFFF_FFFF, 6'd63, 1'b0);
		send_number(CMD_LHEX, 32'hDEAD_BEEF, 6'd0, 1'b0);
		send_number(CMD_LHEX, 32'd0, 6'd8, 1'b1);
		send_number(CMD_LHEX, 32'h0000_0ABC, 6'd40, 1'b0);
		send_number(CMD_UHEX, 32'hCAFE_F00D, 6'd10, 1'b1);
		send_number(CMD_UHEX, 32'hFFFF_FFFF, 6'd0, 1'b0);
		send_number(CMD_PTR, 32'd0, 6'd20, 1'b0);
		send_number(CMD_PTR, 32'hFFFF_FFFF, 6'd0, 1'b1);
		send_number(CMD_PTR, 32'h1234_ABCD, 6'd63, 1'b0);
		// Unused codes must leave no trace on the output.
		send_number(3'd5, 32'h1234_5678, 6'd9, 1'b1);
		send_number(3'd6, 32'hFFFF_FFFF, 6'd63, 1'b0);
		send_number(3'd7, 32'd0, 6'd0, 1'b1);

		sent = 0;
		idx = 0;
		while (sent < RAND_ITEMS) begin
			tx_calm <= (idx >= 50 && idx < 80);
			if ($urandom_range(99) < 8)
				cmd = 3'($urandom_range(7, 5));
			else
				cmd = 3'($urandom_range(4));
			if ($urandom_range(99) < 20)
				field_w = 6'($urandom_range(63));
			else
				field_w = 6'($urandom_range(12));
			send_number(cmd, pick_operand(), field_w, 1'($urandom));
			if (cmd <= CMD_PTR)
				sent++;
			idx++;
		end
		s_tvalid <= 1'b0;
		tx_calm <= 1'b0;

		// One edge so that the count includes the last accepted number.
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (err_count == 0 && pending_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
